>>> rtl/core/ipfixfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfixfr_pkg
// Types, constants and codes shared by the IPFIX message framer core.
// ----------------------------------------------------------------------------
package ipfixfr_pkg;

  localparam int BLOCK_CAPACITY     = 1048576;
  localparam int BLOCK_HEADER_BYTES = 32;
  localparam int MSG_HDR_LEN        = 16;
  localparam int SET_HDR_LEN        = 4;
  localparam int SIZE_FIELD_MAX     = 65535;
  localparam int MAX_RECORD         = SIZE_FIELD_MAX - MSG_HDR_LEN - SET_HDR_LEN;
  localparam int BLOCK_LIMIT        = BLOCK_HEADER_BYTES + BLOCK_CAPACITY;

  localparam int POS_W   = 21;
  localparam int SUM_W   = POS_W + 1;
  localparam int SIZE_W  = 16;
  localparam int TID_W   = 16;
  localparam int TIME_W  = 32;
  localparam int SEQ_W   = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 1;

  // Most words one item can produce, and the widths that index them.
  localparam int RES_DEPTH = 5;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int RES_IDX_W = $clog2(RES_DEPTH);

  localparam logic [SIZE_W-1:0] MAX_MSG_SIZE_RST = 16'd1400;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_MSG_SIZE = 1'b0,
    REG_DOMAIN_ID    = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    FUNC_ADD   = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    KIND_MSG_LEN   = 3'd0,
    KIND_SET_LEN   = 3'd1,
    KIND_NEW_MSG   = 3'd2,
    KIND_NEW_SET   = 3'd3,
    KIND_RECORD    = 3'd4,
    KIND_BLOCK_LEN = 3'd5,
    KIND_EMPTY     = 3'd6,
    KIND_REJECTED  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BLOCK_FULL = 2'd1,
    ERR_OVERSIZE   = 2'd2
  } err_t;

  typedef struct packed {
    func_t             func;
    logic [SIZE_W-1:0] record_size;
    logic [TID_W-1:0]  template_id;
    logic [TIME_W-1:0] export_secs;
  } in_word_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  value;
    logic [SEQ_W-1:0]  seq_num;
    logic [TIME_W-1:0] msg_time;
    logic [POS_W-1:0]  record_count;
    err_t              error;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  write_pos;
    logic [POS_W-1:0]  msg_start;
    logic [POS_W-1:0]  set_start;
    logic [TID_W-1:0]  set_id;
    logic [TIME_W-1:0] cur_time;
    logic [SEQ_W-1:0]  next_seq;
    logic [POS_W-1:0]  rec_count;
  } frame_state_t;

  typedef out_word_t [RES_DEPTH-1:0] res_list_t;

  localparam logic [POS_W-1:0] HDR_POS = POS_W'(BLOCK_HEADER_BYTES);

  function automatic out_word_t mk_word(kind_t k, logic [POS_W-1:0] off,
                                        logic [POS_W-1:0] val,
                                        logic [SEQ_W-1:0] seq,
                                        logic [TIME_W-1:0] tm,
                                        logic [POS_W-1:0] cnt, err_t err);
    out_word_t w;
    w.kind         = k;
    w.offset       = off;
    w.value        = val;
    w.seq_num      = seq;
    w.msg_time     = tm;
    w.record_count = cnt;
    w.error        = err;
    w.last         = 1'b0;
    return w;
  endfunction

endpackage

>>> rtl/core/ipfix_message_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfix_message_framer_core
// Frames IPFIX data records into messages and sets inside one data block.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of add or flush words.
//   out_* : valid/ready channel of placement words (message/set length
//           patches, message and set headers, record placement, block length,
//           empty or rejected). The final word of each item has last set.
//   cfg_* : write port; max_msg_size takes effect on the next item, the
//           observation domain id write is taken and dropped and does not
//           affect placement.
//   The first word of an item is registered and offered in the cycle after it is taken.
//   Throughput: one word per cycle on the output while out_ready is high; an
//   item makes 1 to 5 words, and the single result bank holds one item. A new
//   item is taken in the cycle the previous item's last word leaves.
//   Reset: positions return to the block header size, counters to zero and
//   max_msg_size to 1400; no clearing pass.
//   Stall: while out_ready is low the pending words hold and in_ready drops.
// ----------------------------------------------------------------------------
module ipfix_message_framer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ipfixfr_pkg::in_word_t                in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ipfixfr_pkg::out_word_t               out_data,
  input  logic                                 cfg_we,
  input  logic [ipfixfr_pkg::IDX_W-1:0]        cfg_index,
  input  logic [ipfixfr_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [ipfixfr_pkg::SIZE_W-1:0]     max_msg_size_r;
  ipfixfr_pkg::frame_state_t          st_r;
  ipfixfr_pkg::frame_state_t          st_nxt;
  ipfixfr_pkg::res_list_t             res;
  logic [ipfixfr_pkg::RES_CNT_W-1:0]  res_cnt;
  logic                               accept;

  assign accept = in_valid && in_ready;

  ipfixfr_decide u_decide (
    .item         (in_data),
    .st           (st_r),
    .max_msg_size (max_msg_size_r),
    .res          (res),
    .res_cnt      (res_cnt),
    .st_nxt       (st_nxt)
  );

  ipfixfr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_res  (res),
    .load_cnt  (res_cnt),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.write_pos <= ipfixfr_pkg::HDR_POS;
      st_r.msg_start <= ipfixfr_pkg::HDR_POS;
      st_r.set_start <= ipfixfr_pkg::HDR_POS;
      st_r.set_id    <= '0;
      st_r.cur_time  <= '0;
      st_r.next_seq  <= '0;
      st_r.rec_count <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Domain id writes are taken and dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_size_r <= ipfixfr_pkg::MAX_MSG_SIZE_RST;
    end else if (cfg_we && (cfg_index == ipfixfr_pkg::REG_MAX_MSG_SIZE)) begin
      max_msg_size_r <= cfg_wdata[ipfixfr_pkg::SIZE_W-1:0];
    end
  end

endmodule

>>> rtl/core/ipfixfr_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfixfr_decide
// Framing decision: from the current positions and one input word, build the
// list of placement words and the next framing state.
// ----------------------------------------------------------------------------
module ipfixfr_decide (
  input  ipfixfr_pkg::in_word_t                    item,
  input  ipfixfr_pkg::frame_state_t                st,
  input  logic [ipfixfr_pkg::SIZE_W-1:0]           max_msg_size,
  output ipfixfr_pkg::res_list_t                   res,
  output logic [ipfixfr_pkg::RES_CNT_W-1:0]        res_cnt,
  output ipfixfr_pkg::frame_state_t                st_nxt
);

  logic [ipfixfr_pkg::SUM_W-1:0]     used;
  logic [ipfixfr_pkg::SUM_W-1:0]     room;
  logic [ipfixfr_pkg::SUM_W-1:0]     limit;
  logic                              too_full;
  logic                              too_big;
  logic                              same_set;
  logic [ipfixfr_pkg::SIZE_W:0]      add;
  logic [ipfixfr_pkg::POS_W-1:0]     msize;
  logic [ipfixfr_pkg::POS_W-1:0]     set_len;
  logic [ipfixfr_pkg::SUM_W-1:0]     msg_sum;
  logic                              close_msg;
  logic                              open_msg;
  logic [ipfixfr_pkg::POS_W-1:0]     size_pos;
  logic [ipfixfr_pkg::POS_W-1:0]     tid_pos;
  logic [ipfixfr_pkg::POS_W-1:0]     rec_pos;
  logic [ipfixfr_pkg::RES_CNT_W-1:0] n;

  assign limit    = ipfixfr_pkg::SUM_W'(ipfixfr_pkg::BLOCK_LIMIT);
  assign used     = {1'b0, st.write_pos} +
                    ipfixfr_pkg::SUM_W'(ipfixfr_pkg::MSG_HDR_LEN + ipfixfr_pkg::SET_HDR_LEN);
  // Room left for a record after worst-case headers, floored at zero.
  assign room     = (used < limit) ? (limit - used) : '0;
  assign too_full = ipfixfr_pkg::SUM_W'(item.record_size) > room;
  assign too_big  = item.record_size > ipfixfr_pkg::SIZE_W'(ipfixfr_pkg::MAX_RECORD);

  assign same_set = st.set_id == item.template_id;
  assign add      = same_set ? {1'b0, item.record_size}
                             : {1'b0, item.record_size} +
                               (ipfixfr_pkg::SIZE_W+1)'(ipfixfr_pkg::SET_HDR_LEN);
  assign msize    = st.write_pos - st.msg_start;
  assign set_len  = st.write_pos - st.set_start;
  assign msg_sum  = {1'b0, msize} + ipfixfr_pkg::SUM_W'(add);

  assign close_msg = (msize != '0) &&
                     ((msg_sum > ipfixfr_pkg::SUM_W'(max_msg_size)) ||
                      (st.cur_time != item.export_secs));
  assign open_msg  = (msize == '0) || close_msg;

  assign size_pos = ipfixfr_pkg::POS_W'(item.record_size);
  assign tid_pos  = ipfixfr_pkg::POS_W'(item.template_id);

  always_comb begin
    res     = '0;
    n       = '0;
    st_nxt  = st;
    rec_pos = st.write_pos;
    if (item.func == ipfixfr_pkg::FUNC_FLUSH) begin
      if (st.write_pos <= ipfixfr_pkg::HDR_POS) begin
        res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_EMPTY, '0, '0, '0, '0, '0,
                                      ipfixfr_pkg::ERR_NONE);
        n = 3'd1;
      end else begin
        res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_MSG_LEN, st.msg_start, msize,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        res[1] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_SET_LEN, st.set_start, set_len,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        res[2] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_BLOCK_LEN, '0, st.write_pos,
                                      '0, '0, st.rec_count, ipfixfr_pkg::ERR_NONE);
        n = 3'd3;
        // Reset positions; sequence and time carry over.
        st_nxt.write_pos = ipfixfr_pkg::HDR_POS;
        st_nxt.msg_start = ipfixfr_pkg::HDR_POS;
        st_nxt.set_start = ipfixfr_pkg::HDR_POS;
        st_nxt.set_id    = '0;
        st_nxt.rec_count = '0;
      end
    end else if (too_full) begin
      res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_REJECTED, '0, '0, '0, '0, '0,
                                    ipfixfr_pkg::ERR_BLOCK_FULL);
      n = 3'd1;
    end else if (too_big) begin
      res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_REJECTED, '0, '0, '0, '0, '0,
                                    ipfixfr_pkg::ERR_OVERSIZE);
      n = 3'd1;
    end else begin
      if (close_msg) begin
        res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_MSG_LEN, st.msg_start, msize,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        res[1] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_SET_LEN, st.set_start, set_len,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        n = 3'd2;
      end
      if (open_msg) begin
        st_nxt.msg_start = st.write_pos;
        st_nxt.set_start = st.write_pos + ipfixfr_pkg::POS_W'(ipfixfr_pkg::MSG_HDR_LEN);
        st_nxt.cur_time  = item.export_secs;
        st_nxt.set_id    = item.template_id;
        rec_pos = st.write_pos +
                  ipfixfr_pkg::POS_W'(ipfixfr_pkg::MSG_HDR_LEN + ipfixfr_pkg::SET_HDR_LEN);
        res[n[ipfixfr_pkg::RES_IDX_W-1:0]] =
          ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_NEW_MSG, st.write_pos, '0, st.next_seq,
                               item.export_secs, '0, ipfixfr_pkg::ERR_NONE);
        res[n[ipfixfr_pkg::RES_IDX_W-1:0] + 3'd1] =
          ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_NEW_SET, st_nxt.set_start, tid_pos,
                               '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        n = n + 3'd2;
      end else if (!same_set) begin
        st_nxt.set_id    = item.template_id;
        st_nxt.set_start = st.write_pos;
        rec_pos = st.write_pos + ipfixfr_pkg::POS_W'(ipfixfr_pkg::SET_HDR_LEN);
        res[0] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_SET_LEN, st.set_start, set_len,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        res[1] = ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_NEW_SET, st.write_pos, tid_pos,
                                      '0, '0, '0, ipfixfr_pkg::ERR_NONE);
        n = 3'd2;
      end
      res[n[ipfixfr_pkg::RES_IDX_W-1:0]] =
        ipfixfr_pkg::mk_word(ipfixfr_pkg::KIND_RECORD, rec_pos, size_pos, '0, '0, '0,
                             ipfixfr_pkg::ERR_NONE);
      n = n + 3'd1;
      st_nxt.write_pos = rec_pos + size_pos;
      st_nxt.next_seq  = st.next_seq + 32'd1;
      st_nxt.rec_count = st.rec_count + ipfixfr_pkg::POS_W'(1);
    end
  end

  assign res_cnt = n;

endmodule

>>> rtl/core/ipfixfr_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfixfr_outq
// Result register bank: holds the words of one item and hands them out one
// per cycle while out_ready is high, marking the final one.
// ----------------------------------------------------------------------------
module ipfixfr_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  ipfixfr_pkg::res_list_t              load_res,
  input  logic [ipfixfr_pkg::RES_CNT_W-1:0]   load_cnt,
  output logic                                free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ipfixfr_pkg::out_word_t              out_data
);

  ipfixfr_pkg::res_list_t                 slots_r;
  logic [ipfixfr_pkg::RES_CNT_W-1:0]      cnt_r;
  logic [ipfixfr_pkg::RES_IDX_W-1:0]      rd_r;
  logic                                   is_last;
  logic                                   pop;

  assign out_valid = cnt_r != '0;
  assign is_last   = ipfixfr_pkg::RES_CNT_W'(rd_r) == (cnt_r - 3'd1);
  assign pop       = out_valid && out_ready;
  // Take a new item once the final word leaves, even in the same cycle.
  assign free      = (cnt_r == '0) || (pop && is_last);

  always_comb begin
    out_data      = slots_r[rd_r];
    out_data.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
      rd_r  <= '0;
    end else if (pop && is_last) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (pop) begin
      rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= load_res;
    end
  end

endmodule

>>> sim/ipfix_message_framer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfix_message_framer_core_test
// Self-checking bench for the IPFIX message framer core. A directed pass walks
// through the framing corners. A block-fill pass drives the block to full.
// Random add/flush words then run under several message limits, some passes
// with sender idles or receiver stalls. Every placement word is predicted in
// the bench and compared field by field.
// ----------------------------------------------------------------------------
module ipfix_message_framer_core_test;
  import ipfixfr_pkg::*;

  // Tracks the framing state and holds the placement words still to come.
  class placement_scoreboard;
    out_word_t         placements_due[$];
    int unsigned       mismatches;
    logic [15:0]       max_msg;
    logic [POS_W-1:0]  wr_pos;
    logic [POS_W-1:0]  msg_pos;
    logic [POS_W-1:0]  set_pos;
    logic [POS_W-1:0]  rec_cnt;
    logic [TID_W-1:0]  set_id;
    logic [TIME_W-1:0] cur_time;
    logic [SEQ_W-1:0]  seq;

    function new();
      mismatches = 0;
      max_msg    = MAX_MSG_SIZE_RST;
      cur_time   = '0;
      seq        = '0;
      restart_block();
    endfunction

    function void restart_block();
      wr_pos  = HDR_POS;
      msg_pos = HDR_POS;
      set_pos = HDR_POS;
      set_id  = '0;
      rec_cnt = '0;
    endfunction

    function out_word_t placement(kind_t k, logic [POS_W-1:0] off,
                                  logic [POS_W-1:0] val, logic [SEQ_W-1:0] sq,
                                  logic [TIME_W-1:0] tm, logic [POS_W-1:0] cnt,
                                  err_t err);
      out_word_t p;
      p.kind         = k;
      p.offset       = off;
      p.value        = val;
      p.seq_num      = sq;
      p.msg_time     = tm;
      p.record_count = cnt;
      p.error        = err;
      p.last         = 1'b0;
      return p;
    endfunction

    // Work out the placement words of one accepted item and advance the state.
    function void take_item(in_word_t w);
      out_word_t   words[$];
      int unsigned used;
      int unsigned room;
      int unsigned grow;
      int unsigned msize;
      if (w.func == FUNC_FLUSH) begin
        if (wr_pos <= HDR_POS) begin
          words.push_back(placement(KIND_EMPTY, 0, 0, 0, 0, 0, ERR_NONE));
        end else begin
          words.push_back(placement(KIND_MSG_LEN, msg_pos, wr_pos - msg_pos, 0, 0, 0,
                                    ERR_NONE));
          words.push_back(placement(KIND_SET_LEN, set_pos, wr_pos - set_pos, 0, 0, 0,
                                    ERR_NONE));
          words.push_back(placement(KIND_BLOCK_LEN, 0, wr_pos, 0, 0, rec_cnt, ERR_NONE));
          restart_block();
        end
      end else begin
        used = wr_pos + MSG_HDR_LEN + SET_HDR_LEN;
        room = (used < BLOCK_LIMIT) ? BLOCK_LIMIT - used : 0;
        if (w.record_size > room) begin
          words.push_back(placement(KIND_REJECTED, 0, 0, 0, 0, 0, ERR_BLOCK_FULL));
        end else if (w.record_size > MAX_RECORD) begin
          words.push_back(placement(KIND_REJECTED, 0, 0, 0, 0, 0, ERR_OVERSIZE));
        end else begin
          grow  = (set_id == w.template_id) ? w.record_size : w.record_size + SET_HDR_LEN;
          msize = wr_pos - msg_pos;
          // close the open message on overflow or a new export time
          if (msize != 0 && (msize + grow > max_msg || cur_time != w.export_secs)) begin
            words.push_back(placement(KIND_MSG_LEN, msg_pos, POS_W'(msize), 0, 0, 0,
                                      ERR_NONE));
            words.push_back(placement(KIND_SET_LEN, set_pos, wr_pos - set_pos, 0, 0, 0,
                                      ERR_NONE));
            msize = 0;
          end
          if (msize == 0) begin
            msg_pos  = wr_pos;
            set_pos  = POS_W'(wr_pos + MSG_HDR_LEN);
            wr_pos   = POS_W'(set_pos + SET_HDR_LEN);
            cur_time = w.export_secs;
            set_id   = w.template_id;
            words.push_back(placement(KIND_NEW_MSG, msg_pos, 0, seq, cur_time, 0, ERR_NONE));
            words.push_back(placement(KIND_NEW_SET, set_pos, POS_W'(w.template_id), 0, 0, 0,
                                      ERR_NONE));
          end else if (set_id != w.template_id) begin
            words.push_back(placement(KIND_SET_LEN, set_pos, wr_pos - set_pos, 0, 0, 0,
                                      ERR_NONE));
            set_id  = w.template_id;
            set_pos = wr_pos;
            wr_pos  = POS_W'(wr_pos + SET_HDR_LEN);
            words.push_back(placement(KIND_NEW_SET, set_pos, POS_W'(w.template_id), 0, 0, 0,
                                      ERR_NONE));
          end
          words.push_back(placement(KIND_RECORD, wr_pos, POS_W'(w.record_size), 0, 0, 0,
                                    ERR_NONE));
          wr_pos  = wr_pos + POS_W'(w.record_size);
          seq     = seq + 32'd1;
          rec_cnt = rec_cnt + POS_W'(1);
        end
      end
      words[words.size() - 1].last = 1'b1;
      foreach (words[i]) placements_due.push_back(words[i]);
    endfunction

    function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (placements_due.size() == 0) begin
        $error("word with nothing pending: kind %0d offset %0d", got.kind, got.offset);
        mismatches++;
        return;
      end
      want = placements_due.pop_front();
      compare("kind", want.kind, got.kind);
      compare("offset", want.offset, got.offset);
      compare("value", want.value, got.value);
      compare("seq_num", want.seq_num, got.seq_num);
      compare("msg_time", want.msg_time, got.msg_time);
      compare("record_count", want.record_count, got.record_count);
      compare("error", want.error, got.error);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int unsigned         in_idle_pct   = 0;
  int unsigned         out_stall_pct = 0;
  logic [TIME_W-1:0]   epoch         = '0;
  placement_scoreboard board;

  always #4 clk = ~clk;

  ipfix_message_framer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_word(out_data);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic in_word_t mk_item(func_t f, logic [SIZE_W-1:0] sz,
                                       logic [TID_W-1:0] tid, logic [TIME_W-1:0] tm);
    in_word_t w;
    w.func        = f;
    w.record_size = sz;
    w.template_id = tid;
    w.export_secs = tm;
    return w;
  endfunction

  // Mostly small records in a few templates at a steady export time.
  function automatic in_word_t random_item();
    int unsigned       pick;
    logic [SIZE_W-1:0] sz;
    logic [TID_W-1:0]  tid;
    pick = $urandom_range(99);
    if (pick < 55)      sz = SIZE_W'($urandom_range(64));
    else if (pick < 80) sz = SIZE_W'($urandom_range(board.max_msg));
    else if (pick < 90) sz = SIZE_W'($urandom_range(16'hFFFF));
    else if (pick < 95) sz = SIZE_W'($urandom_range(16'hFFFF, MAX_RECORD + 1));
    else                sz = '0;
    pick = $urandom_range(99);
    if (pick < 70)      tid = TID_W'(16'd256 + $urandom_range(2));
    else if (pick < 90) tid = board.set_id;
    else                tid = TID_W'($urandom);
    pick = $urandom_range(99);
    if (pick >= 95)      epoch = $urandom;
    else if (pick >= 80) epoch = epoch + 32'd1;
    if ($urandom_range(99) < 6) begin
      return mk_item(FUNC_FLUSH, SIZE_W'($urandom), TID_W'($urandom), $urandom);
    end
    return mk_item(FUNC_ADD, sz, tid, epoch);
  endfunction

  task automatic send_item(input in_word_t w);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.take_item(w);
  endtask

  // Drop valid and wait until every pending word has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.placements_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] msg_limit, input logic [31:0] domain);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_MSG_SIZE;
    cfg_wdata <= CFG_W'(msg_limit);
    @(posedge clk);
    cfg_index <= REG_DOMAIN_ID;
    cfg_wdata <= domain;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.max_msg = msg_limit;
  endtask

  task automatic run_directed();
    send_item(mk_item(FUNC_FLUSH, 0, 0, 0));
    send_item(mk_item(FUNC_ADD, 0, 0, 0));
    send_item(mk_item(FUNC_ADD, 100, 0, 0));
    send_item(mk_item(FUNC_ADD, 50, 16'hFFFF, 0));
    send_item(mk_item(FUNC_ADD, 1200, 16'hFFFF, 0));
    send_item(mk_item(FUNC_ADD, 300, 16'hFFFF, 0));
    send_item(mk_item(FUNC_ADD, 10, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_ADD, SIZE_W'(MAX_RECORD), 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_ADD, SIZE_W'(MAX_RECORD + 1), 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_FLUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_item(FUNC_FLUSH, 0, 0, 0));
    send_item(mk_item(FUNC_ADD, 16'hFFFF, 0, 0));
    send_item(mk_item(FUNC_ADD, 16'h8000, 16'h8000, 32'h8000_0000));
    send_item(mk_item(FUNC_ADD, 1, 1, 1));
    send_item(mk_item(FUNC_FLUSH, 0, 0, 0));
  endtask

  // Fill the block with maximum records, then probe the full block.
  task automatic fill_block();
    send_item(mk_item(FUNC_FLUSH, 0, 0, 0));
    repeat (17) send_item(mk_item(FUNC_ADD, SIZE_W'(MAX_RECORD), TID_W'($urandom),
                                  $urandom));
    send_item(mk_item(FUNC_ADD, 0, 16'h0101, $urandom));
    send_item(mk_item(FUNC_ADD, 1, 16'h0101, $urandom));
    send_item(mk_item(FUNC_ADD, 16'hFFFF, 16'h0101, $urandom));
    send_item(mk_item(FUNC_FLUSH, 0, 0, 0));
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    configure(16'd20, 32'hFFFF_FFFF);
    repeat (40) send_item(random_item());

    configure(16'hFFFF, 32'h0);
    in_idle_pct = 64;
    fill_block();
    repeat (30) send_item(random_item());

    configure(16'($urandom_range(2000, 20)), $urandom);
    in_idle_pct   = 0;
    out_stall_pct = 64;
    repeat (60) send_item(random_item());

    configure(16'd1400, $urandom);
    in_idle_pct   = 23;
    out_stall_pct = 23;
    repeat (60) send_item(random_item());

    settle();
    repeat (12) @(posedge clk);
    if (board.mismatches == 0 && board.placements_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
